>>> src/dpc_pkg.sv
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types and constants for the duplicate point clusterer.
// ----------------------------------------------------------------------------
`default_nettype none

package dpc_pkg;

  // set capacity and coordinate format
  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 24;

  // memory addressing and set counters (counters hold MAX_POINTS itself)
  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = ADDR_W + 1;

  // distance arithmetic: |a-b| fits COORD_BITS, three squares need two more bits
  localparam int EPS_W = 52;
  localparam int MAG_W = COORD_BITS;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int SUM_W = SQ_W + 2;
  localparam int CMP_W = (SUM_W > EPS_W) ? SUM_W : EPS_W;

  // result field widths
  localparam int IDX_W     = 10;
  localparam int DUP_W     = 11;
  localparam int DUPCNT_W  = 10;

  localparam logic [IDX_W-1:0]    IDX_FULL = '1;
  localparam logic [DUP_W-1:0]    DUP_NONE = '1;
  localparam logic [DUPCNT_W-1:0] DUP_MAX  = '1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // one stored representative: coordinates and its index within the set
  typedef struct packed {
    coord_t              x;
    coord_t              y;
    coord_t              z;
    logic [ADDR_W-1:0]   pidx;
  } rep_entry_t;

  // status from the distance pipeline back to the scan control
  typedef struct packed {
    logic                busy;
    logic                hit;
    logic [ADDR_W-1:0]   hit_index;
  } dist_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

>>> src/dpc_in_if.sv
// ----------------------------------------------------------------------------
// dpc_in_if
// Point input channel: valid/ready handshake with one 3D point per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpc_in_if import dpc_pkg::*; ();

  logic   valid;
  logic   ready;
  coord_t coord_x;
  coord_t coord_y;
  coord_t coord_z;
  logic   first_of_set;

  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  output first_of_set, input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                  input first_of_set, output ready);

endinterface

`default_nettype wire

>>> src/dpc_out_if.sv
// ----------------------------------------------------------------------------
// dpc_out_if
// Result channel: valid/ready handshake with one classification per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpc_out_if import dpc_pkg::*; ();

  logic                       valid;
  logic                       ready;
  logic [IDX_W-1:0]           point_index;
  logic signed [DUP_W-1:0]    duplicate_of;
  logic [DUPCNT_W-1:0]        dup_count;
  logic                       overflow;

  modport source (output valid, output point_index, output duplicate_of,
                  output dup_count, output overflow, input ready);
  modport sink   (input valid, input point_index, input duplicate_of,
                  input dup_count, input overflow, output ready);

endinterface

`default_nettype wire

>>> src/dpc_dist.sv
// ----------------------------------------------------------------------------
// dpc_dist
// Squared distance pipeline: difference magnitude, square, then sum and
// inclusive compare against the tolerance. Takes one representative a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dpc_dist import dpc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               flush,
  input  wire logic               in_valid,
  input  wire coord_t             pt_x,
  input  wire coord_t             pt_y,
  input  wire coord_t             pt_z,
  input  wire rep_entry_t         rep,
  input  wire logic [EPS_W-1:0]   eps,
  output dist_status_t            status
);

  logic signed [COORD_BITS:0] dx, dy, dz;
  logic [MAG_W-1:0]           mag_x, mag_y, mag_z;
  logic [ADDR_W-1:0]          pidx_a;
  logic                       valid_a;
  logic [SQ_W-1:0]            sq_x, sq_y, sq_z;
  logic [ADDR_W-1:0]          pidx_b;
  logic                       valid_b;
  logic [SUM_W-1:0]           dist_sum;
  logic                       near;

  // signed differences, one bit wider than a coordinate
  always_comb begin
    dx = (COORD_BITS+1)'(pt_x) - (COORD_BITS+1)'(rep.x);
    dy = (COORD_BITS+1)'(pt_y) - (COORD_BITS+1)'(rep.y);
    dz = (COORD_BITS+1)'(pt_z) - (COORD_BITS+1)'(rep.z);
  end

  // stage a: magnitudes
  always_ff @(posedge clk) begin
    mag_x  <= MAG_W'(dx[COORD_BITS] ? -dx : dx);
    mag_y  <= MAG_W'(dy[COORD_BITS] ? -dy : dy);
    mag_z  <= MAG_W'(dz[COORD_BITS] ? -dz : dz);
    pidx_a <= rep.pidx;
    if (rst || flush) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= in_valid;
    end
  end

  // stage b: squares
  always_ff @(posedge clk) begin
    sq_x   <= mag_x * mag_x;
    sq_y   <= mag_y * mag_y;
    sq_z   <= mag_z * mag_z;
    pidx_b <= pidx_a;
    if (rst || flush) begin
      valid_b <= 1'b0;
    end else begin
      valid_b <= valid_a;
    end
  end

  // sum of squares and inclusive tolerance test
  always_comb begin
    dist_sum = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
    near     = CMP_W'(dist_sum) <= CMP_W'(eps);
  end

  assign status.busy      = valid_a | valid_b;
  assign status.hit       = valid_b & near;
  assign status.hit_index = pidx_b;

endmodule

`default_nettype wire

>>> src/duplicate_point_clusterer_top.sv
// ----------------------------------------------------------------------------
// duplicate_point_clusterer_top
// Greedy epsilon deduplication of 3D points against stored representatives.
// ----------------------------------------------------------------------------
// Points are handled one at a time. Each accepted point is compared with the
// stored representatives of its set in arrival order, one representative per
// cycle from a representative memory with one read port and one write port.
// The scan stops at the first representative within tolerance, or after the
// stored count of representatives (at most 1024) when none claims the point.
// A point arriving into a full set skips the scan. A result still waiting at
// the output holds the next one back for as long as the receiver stalls. The
// tolerance register is to be written only while the block is idle: the user
// is bound by this, the block itself does not enforce it. The representative
// memory needs no clearing after reset: entries at or above the stored count
// are never used.
`default_nettype none

module duplicate_point_clusterer_top import dpc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [EPS_W-1:0]  cfg_wr_data,
  dpc_in_if.sink                 in_pt,
  dpc_out_if.source              out_res
);

  // representative memory
  rep_entry_t            rep_mem [MAX_POINTS];
  rep_entry_t            rep_q;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  mem_we;
  rep_entry_t            mem_wdata;

  // control and set state
  state_t                state, state_next;
  logic [EPS_W-1:0]      eps_squared;
  coord_t                pt_x, pt_y, pt_z;
  logic [CNT_W-1:0]      rep_count;
  logic [CNT_W-1:0]      points_seen;
  logic [DUPCNT_W-1:0]   duplicates_seen;
  logic [CNT_W-1:0]      issue_k;
  logic                  rd_valid;
  logic                  found;
  logic [ADDR_W-1:0]     dup_idx;
  logic                  ovf;

  // output register
  logic                  out_valid;
  logic [IDX_W-1:0]      out_point_index;
  logic [DUP_W-1:0]      out_duplicate_of;
  logic [DUPCNT_W-1:0]   out_dup_count;
  logic                  out_overflow;

  // control decode
  logic                  in_fire;
  logic                  issue;
  logic                  scan_done;
  logic                  out_load;
  logic                  set_full;
  logic [DUPCNT_W-1:0]   dups_next;
  dist_status_t          dist_st;

  assign in_fire  = in_pt.valid & in_pt.ready;
  assign set_full = in_pt.first_of_set ? 1'b0 : (points_seen >= CNT_W'(MAX_POINTS));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_fire) state_next = set_full ? ST_RESULT : ST_SCAN;
      ST_SCAN:   if (scan_done) state_next = ST_RESULT;
      ST_RESULT: if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_pt.ready = 1'b0;
    issue       = 1'b0;
    scan_done   = 1'b0;
    out_load    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_pt.ready = 1'b1;
      end
      ST_SCAN: begin
        issue     = (issue_k < rep_count) && !dist_st.hit;
        scan_done = dist_st.hit ||
                    ((issue_k == rep_count) && !rd_valid && !dist_st.busy);
      end
      ST_RESULT: begin
        out_load = !out_valid || out_res.ready;
      end
      default: begin
        in_pt.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      eps_squared <= '0;
    end else if (cfg_wr_en) begin
      eps_squared <= cfg_wr_data;
    end
  end

  // memory read and write ports
  assign rd_addr = issue_k[ADDR_W-1:0];
  assign mem_we  = out_load && !ovf && !found && (rep_count < CNT_W'(MAX_POINTS));
  always_comb begin
    mem_wdata.x    = pt_x;
    mem_wdata.y    = pt_y;
    mem_wdata.z    = pt_z;
    mem_wdata.pidx = points_seen[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rep_mem[rep_count[ADDR_W-1:0]] <= mem_wdata;
    end
    rep_q <= rep_mem[rd_addr];
  end

  // point latch and scan bookkeeping
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pt_x <= in_pt.coord_x;
      pt_y <= in_pt.coord_y;
      pt_z <= in_pt.coord_z;
    end
    if (dist_st.hit && state == ST_SCAN) begin
      dup_idx <= dist_st.hit_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_k  <= '0;
      rd_valid <= 1'b0;
      found    <= 1'b0;
      ovf      <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (in_fire) begin
        issue_k <= '0;
        found   <= 1'b0;
        ovf     <= set_full;
      end else begin
        if (issue) begin
          issue_k <= issue_k + 1'b1;
        end
        if (dist_st.hit && state == ST_SCAN) begin
          found <= 1'b1;
        end
      end
    end
  end

  // duplicate count after this point, saturating
  assign dups_next = (found && !ovf && duplicates_seen != DUP_MAX) ?
                     duplicates_seen + 1'b1 : duplicates_seen;

  // set counters
  always_ff @(posedge clk) begin
    if (rst) begin
      rep_count       <= '0;
      points_seen     <= '0;
      duplicates_seen <= '0;
    end else if (in_fire && in_pt.first_of_set) begin
      rep_count       <= '0;
      points_seen     <= '0;
      duplicates_seen <= '0;
    end else if (out_load && !ovf) begin
      if (mem_we) begin
        rep_count <= rep_count + 1'b1;
      end
      points_seen     <= points_seen + 1'b1;
      duplicates_seen <= dups_next;
    end
  end

  // distance pipeline
  dpc_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .flush    (in_fire),
    .in_valid (rd_valid),
    .pt_x     (pt_x),
    .pt_y     (pt_y),
    .pt_z     (pt_z),
    .rep      (rep_q),
    .eps      (eps_squared),
    .status   (dist_st)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_res.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_point_index  <= ovf ? IDX_FULL : IDX_W'(points_seen[ADDR_W-1:0]);
      out_duplicate_of <= (ovf || !found) ? DUP_NONE : DUP_W'(dup_idx);
      out_dup_count    <= dups_next;
      out_overflow     <= ovf;
    end
  end

  assign out_res.valid        = out_valid;
  assign out_res.point_index  = out_point_index;
  assign out_res.duplicate_of = out_duplicate_of;
  assign out_res.dup_count    = out_dup_count;
  assign out_res.overflow     = out_overflow;

endmodule

`default_nettype wire

>>> src/dpc_checker.sv
// ----------------------------------------------------------------------------
// dpc_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dpc_checker import dpc_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [IDX_W-1:0]     point_index,
  input wire logic [DUP_W-1:0]     duplicate_of,
  input wire logic [DUPCNT_W-1:0]  dup_count,
  input wire logic                 overflow
);

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(point_index) &&
    $stable(duplicate_of) && $stable(dup_count) && $stable(overflow))
    else $error("result changed while stalled");

  // full set reports no index and no claim
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> point_index == IDX_FULL && duplicate_of == DUP_NONE)
    else $error("overflow result fields wrong");

  // a claiming representative always came earlier in the set
  a_claim: assert property (@(posedge clk) disable iff (rst)
    out_valid && !overflow && duplicate_of != DUP_NONE |->
    duplicate_of < DUP_W'(point_index))
    else $error("claim by a later point");

  // the duplicate count never exceeds the point index, so the first point of a set is never a duplicate
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !overflow |-> DUP_W'(dup_count) <= DUP_W'(point_index))
    else $error("duplicate count exceeds point index");

  // nothing is offered right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind duplicate_point_clusterer_top dpc_checker u_dpc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .point_index  (out_res.point_index),
  .duplicate_of (out_res.duplicate_of),
  .dup_count    (out_res.dup_count),
  .overflow     (out_res.overflow)
);

`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the duplicate point clusterer.
// ----------------------------------------------------------------------------
// Points are queued by the stimulus process and sent by a clocked driver in
// bursts with random gaps. Each accepted point is classified by a local
// greedy-epsilon model that keeps its own representatives, set counters and
// tolerance. The expected result is queued and compared field by field with
// the block's results, which are taken by a receiver that stalls in patterns.
// The tolerance changes only between phases, once all results have come back.
// The run covers a directed sweep of boundary points, clustered sets under
// several tolerances from zero to full width, and noise.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dpc_pkg::*;

  localparam int     WATCHDOG_LIMIT = 20000;
  localparam int     TAIL_CYCLES    = 64;
  localparam coord_t COORD_MAX      = 24'sh7FFFFF;
  localparam coord_t COORD_MIN      = 24'sh800000;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   first;
  } point_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        point_index;
    logic signed [DUP_W-1:0] duplicate_of;
    logic [DUPCNT_W-1:0]     dup_count;
    logic                    overflow;
  } point_verdict_t;

  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_RARE_STALL,
    RX_PERIODIC
  } rx_mode_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [EPS_W-1:0] cfg_wr_data = '0;

  dpc_in_if  in_pt ();
  dpc_out_if out_res ();

  duplicate_point_clusterer_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_pt       (in_pt),
    .out_res     (out_res)
  );

  always #5 clk = ~clk;

  // points waiting to be sent and results waiting to arrive
  point_item_t    pending_points[$];
  point_verdict_t expected_verdicts[$];

  // model of the set: tolerance, representatives and counters
  logic [EPS_W-1:0]  tol_eps = '0;
  coord_t            rep_x [MAX_POINTS];
  coord_t            rep_y [MAX_POINTS];
  coord_t            rep_z [MAX_POINTS];
  logic [ADDR_W-1:0] rep_pidx [MAX_POINTS];
  int                num_reps = 0;
  int                set_points = 0;
  int                set_dups = 0;

  // run statistics
  int error_count = 0;
  int points_accepted = 0;
  int sets_started = 0;
  int results_checked = 0;
  int claimed_results = 0;
  int new_rep_results = 0;

  // sender and receiver pacing
  int       burst_left = 0;
  int       gap_left = 0;
  rx_mode_t rx_mode = RX_ALWAYS;
  int       mode_left = 0;
  int       rx_cycle = 0;
  int       idle_cycles = 0;

  // greedy classification of one point against the stored representatives
  function automatic point_verdict_t classify_point(coord_t x, coord_t y, coord_t z,
                                                    logic first);
    point_verdict_t v;
    longint         dx;
    longint         dy;
    longint         dz;
    longint         dist_sq;
    int             claim;
    int             k;
    if (first) begin
      num_reps   = 0;
      set_points = 0;
      set_dups   = 0;
    end
    v.overflow = 1'b0;
    if (set_points >= MAX_POINTS) begin
      v.point_index  = IDX_FULL;
      v.duplicate_of = DUP_NONE;
      v.dup_count    = set_dups[DUPCNT_W-1:0];
      v.overflow     = 1'b1;
      return v;
    end
    // first representative within tolerance wins
    claim = -1;
    for (k = 0; k < num_reps && claim < 0; k++) begin
      dx      = longint'(x) - longint'(rep_x[k]);
      dy      = longint'(y) - longint'(rep_y[k]);
      dz      = longint'(z) - longint'(rep_z[k]);
      dist_sq = dx * dx + dy * dy + dz * dz;
      if (dist_sq <= longint'({12'd0, tol_eps}))
        claim = k;
    end
    if (claim < 0) begin
      if (num_reps < MAX_POINTS) begin
        rep_x[num_reps]    = x;
        rep_y[num_reps]    = y;
        rep_z[num_reps]    = z;
        rep_pidx[num_reps] = set_points[ADDR_W-1:0];
        num_reps++;
      end
      v.duplicate_of = DUP_NONE;
    end else begin
      v.duplicate_of = {1'b0, rep_pidx[claim]};
      if (set_dups < int'(DUP_MAX))
        set_dups++;
    end
    v.point_index = set_points[IDX_W-1:0];
    set_points++;
    v.dup_count = set_dups[DUPCNT_W-1:0];
    return v;
  endfunction

  // point driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin : drive_points
    point_item_t item;
    logic        fire;
    fire = in_pt.valid && in_pt.ready;
    if (rst) begin
      in_pt.valid <= 1'b0;
    end else begin
      if (fire) begin
        expected_verdicts.push_back(classify_point(in_pt.coord_x, in_pt.coord_y,
                                                   in_pt.coord_z, in_pt.first_of_set));
        points_accepted++;
        if (in_pt.first_of_set)
          sets_started++;
      end
      if (!in_pt.valid || fire) begin
        if (gap_left > 0 || pending_points.size() == 0) begin
          if (gap_left > 0)
            gap_left--;
          in_pt.valid <= 1'b0;
        end else begin
          item = pending_points.pop_front();
          in_pt.valid        <= 1'b1;
          in_pt.coord_x      <= item.x;
          in_pt.coord_y      <= item.y;
          in_pt.coord_z      <= item.z;
          in_pt.first_of_set <= item.first;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // a third of the bursts run back to back, some of them long
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // result monitor: compare each transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    point_verdict_t want;
    if (rst) begin
      out_res.ready <= 1'b0;
    end else begin
      if (out_res.valid && out_res.ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result with no point pending: point_index %0d", out_res.point_index);
          error_count++;
        end else begin
          want = expected_verdicts.pop_front();
          results_checked++;
          if (want.duplicate_of == DUP_NONE)
            new_rep_results++;
          else
            claimed_results++;
          if (out_res.point_index !== want.point_index) begin
            $error("point_index: expected %0d, got %0d", want.point_index,
                   out_res.point_index);
            error_count++;
          end
          if (out_res.duplicate_of !== want.duplicate_of) begin
            $error("duplicate_of: expected %0d, got %0d", want.duplicate_of,
                   out_res.duplicate_of);
            error_count++;
          end
          if (out_res.dup_count !== want.dup_count) begin
            $error("dup_count: expected %0d, got %0d", want.dup_count,
                   out_res.dup_count);
            error_count++;
          end
          if (out_res.overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, out_res.overflow);
            error_count++;
          end
        end
      end
      // receiver stall pattern, picked at random and switched after a random span
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      rx_cycle++;
      case (rx_mode)
        RX_ALWAYS:     out_res.ready <= 1'b1;
        RX_COIN:       out_res.ready <= $urandom_range(0, 1);
        RX_RARE_STALL: out_res.ready <= ($urandom_range(0, 7) != 0);
        default:       out_res.ready <= ((rx_cycle % 7) >= 3);
      endcase
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin : watchdog
    if (rst || (in_pt.valid && in_pt.ready) || (out_res.valid && out_res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, expected_verdicts.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_point(coord_t x, coord_t y, coord_t z, logic first);
    point_item_t item;
    item.x     = x;
    item.y     = y;
    item.z     = z;
    item.first = first;
    pending_points.push_back(item);
  endtask

  // tolerance write, only issued while the block is idle
  task automatic write_tolerance(logic [EPS_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tol_eps = value;
    @(negedge clk);
  endtask

  // hold until every queued point has been sent and answered
  task automatic wait_for_drain();
    while (pending_points.size() != 0 || in_pt.valid || expected_verdicts.size() != 0)
      @(negedge clk);
  endtask

  // clustered sets with exact repeats, mixed with full-range noise points
  task automatic queue_random_sets(int count, int spread, int repeat_pct, int noise_pct);
    point_item_t set_pts[$];
    point_item_t p;
    coord_t      cx;
    coord_t      cy;
    coord_t      cz;
    int          n;
    int          i;
    while (count > 0) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        push_point(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                   $urandom_range(0, 3) == 0);
        count--;
      end else begin
        n  = $urandom_range(1, 40);
        cx = coord_t'($urandom);
        cy = coord_t'($urandom);
        cz = coord_t'($urandom);
        set_pts.delete();
        for (i = 0; i < n && count > 0; i++) begin
          if (i > 0 && $urandom_range(0, 99) < repeat_pct) begin
            p = set_pts[$urandom_range(0, set_pts.size() - 1)];
          end else begin
            p.x = coord_t'(int'(cx) + int'($urandom_range(0, 2 * spread)) - spread);
            p.y = coord_t'(int'(cy) + int'($urandom_range(0, 2 * spread)) - spread);
            p.z = coord_t'(int'(cz) + int'($urandom_range(0, 2 * spread)) - spread);
          end
          // a few sets continue the previous one instead of starting fresh
          p.first = (i == 0) && ($urandom_range(0, 99) < 85);
          set_pts.push_back(p);
          pending_points.push_back(p);
          count--;
        end
      end
    end
  endtask

  initial begin : stimulus
    in_pt.valid        = 1'b0;
    in_pt.coord_x      = '0;
    in_pt.coord_y      = '0;
    in_pt.coord_z      = '0;
    in_pt.first_of_set = 1'b0;
    out_res.ready      = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: boundary distances, corner coordinates, first claim wins
    write_tolerance(52'd100);
    push_point(24'sd0, 24'sd0, 24'sd0, 1'b1);
    push_point(24'sd0, 24'sd0, 24'sd0, 1'b0);
    push_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    push_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    push_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    push_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
    push_point(24'sd10, 24'sd0, 24'sd0, 1'b0);    // exactly at tolerance
    push_point(24'sd0, 24'sd11, 24'sd0, 1'b0);    // just outside on one axis
    push_point(24'sd0, 24'sd0, -24'sd10, 1'b0);
    push_point(24'sd6, 24'sd6, 24'sd6, 1'b0);     // only the later rep is close
    push_point(24'sd3, 24'sd5, 24'sd0, 1'b0);     // two reps close, earlier wins
    push_point(COORD_MIN, COORD_MIN, COORD_MIN + 24'sd10, 1'b0);
    push_point(-24'sd1, -24'sd1, -24'sd1, 1'b0);
    push_point(COORD_MAX, COORD_MIN, 24'sd0, 1'b0);
    push_point(COORD_MAX, COORD_MIN, 24'sd0, 1'b1);    // new set clears the old reps
    push_point(COORD_MAX - 24'sd10, COORD_MIN, 24'sd0, 1'b0);
    push_point(24'sd5, 24'sd5, 24'sd5, 1'b1);
    push_point(24'sd0, 24'sd0, 24'sd0, 1'b0);
    push_point(-24'sd7, -24'sd7, -24'sd7, 1'b0);
    push_point(-24'sd1, -24'sd2, -24'sd3, 1'b0);
    wait_for_drain();

    // zero tolerance: only exact repeats are claimed
    write_tolerance('0);
    queue_random_sets(120, 4, 35, 10);
    wait_for_drain();

    // small and medium tolerances with matching cluster spreads
    write_tolerance(EPS_W'($urandom_range(1, 1 << 20)));
    queue_random_sets(140, 1024, 10, 10);
    wait_for_drain();
    write_tolerance(EPS_W'({20'd0, $urandom} << $urandom_range(0, 8)));
    queue_random_sets(130, 1 << 17, 10, 15);
    wait_for_drain();

    // random full-width tolerance, noise-heavy
    write_tolerance(EPS_W'({$urandom, $urandom}) >> $urandom_range(0, 51));
    queue_random_sets(100, 1 << 23, 5, 50);
    wait_for_drain();

    // widest tolerance: every point after the first of a set is claimed
    write_tolerance('1);
    queue_random_sets(20, 1 << 23, 5, 50);
    wait_for_drain();

    // tolerance of one unit: neighbors one step apart
    write_tolerance(52'd1);
    queue_random_sets(50, 1, 20, 10);
    wait_for_drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_verdicts.size() != 0) begin
      $error("%0d results never arrived", expected_verdicts.size());
      error_count++;
    end

    $display("covered: %0d points in %0d sets, %0d claimed, %0d new representatives",
             points_accepted, sets_started, claimed_results, new_rep_results);
    $display("covered: tolerance from zero to full width, bursty sender, %0d results %s",
             results_checked, "taken under four receiver stall patterns");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
